>>> design/dds_cwe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dds_cwe_pkg;

    // command codes
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_RESET  = 3'd1;
    localparam logic [2:0] CMD_MODE   = 3'd2;
    localparam logic [2:0] CMD_FREQ   = 3'd3;
    localparam logic [2:0] CMD_PHASE  = 3'd4;
    localparam logic [2:0] CMD_FSEL   = 3'd5;
    localparam logic [2:0] CMD_PSEL   = 3'd6;

    // output mode codes
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_SINE   = 3'd1;
    localparam logic [2:0] MODE_SQFULL = 3'd2;
    localparam logic [2:0] MODE_SQHALF = 3'd3;
    localparam logic [2:0] MODE_TRI    = 3'd4;

    // control word bits
    localparam logic [15:0] CTL_B28     = 16'h2000;
    localparam logic [15:0] CTL_FSEL    = 16'h0800;
    localparam logic [15:0] CTL_PSEL    = 16'h0400;
    localparam logic [15:0] CTL_RESET   = 16'h0100;
    localparam logic [15:0] CTL_SLEEP1  = 16'h0080;
    localparam logic [15:0] CTL_SLEEP12 = 16'h0040;
    localparam logic [15:0] CTL_OPBITEN = 16'h0020;
    localparam logic [15:0] CTL_DIV2    = 16'h0008;
    localparam logic [15:0] CTL_MODE    = 16'h0002;

    // register address prefixes
    localparam logic [15:0] PFX_FREQ0  = 16'h4000;
    localparam logic [15:0] PFX_FREQ1  = 16'h8000;
    localparam logic [15:0] PFX_PHASE0 = 16'hC000;
    localparam logic [15:0] PFX_PHASE1 = 16'hE000;

    localparam int unsigned MCLK_HZ_DEF = 25000000;
    localparam int unsigned INIT_FREQ   = 1000;
    localparam int unsigned INIT_WORDS  = 15;

    // divisor sizing: twice the top mclk stays below 2^28
    localparam int unsigned DIV_W  = 28;
    localparam int unsigned TW_W   = 28;
    localparam int unsigned PW_W   = 12;
    localparam logic [DIV_W-1:0] PHASE_DIVISOR = DIV_W'(450);
    localparam logic [8:0]       PHASE_ROUND   = 9'd225;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        hold;
        logic [2:0]  wave_mode;
        logic        chan;
        logic [23:0] freq_hz;
        logic [15:0] phase_tenths;
    } t_cmd_item;

    typedef struct packed {
        logic [15:0] spi_word;
        logic        last;
        logic        rejected;
    } t_res_item;

endpackage

`default_nettype wire

>>> design/dds_command_word_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                    payload
// command   in         i_in_valid / o_in_ready      i_in_data  (t_cmd_item)
// word      out        o_out_valid / i_out_ready    o_out_data (t_res_item)
//
// one command at a time; o_in_ready is high only while the sequencer is idle
// set frequency and set phase first work on one shared multiplier:
// a reciprocal estimate, a back-multiply and three compare-and-subtract steps;
// a frequency at or above MCLK_HZ saturates and skips the arithmetic
// other commands emit one word a cycle while i_out_ready is high;
// init, the longest, emits 15 words; a waiting word holds while i_out_ready is low
// i_rst_n is synchronous; it clears the shadow control word to zero

module dds_command_word_encoder_unit
    import dds_cwe_pkg::*;
#(
    parameter int unsigned MCLK_HZ = MCLK_HZ_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_cmd_item i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_res_item      o_out_data
);

    localparam logic [63:0] INIT_TW =
        ((64'(INIT_FREQ) << 29) + 64'(MCLK_HZ)) / (64'(MCLK_HZ) * 64'd2);
    localparam logic [13:0] INIT_LO = INIT_TW[13:0];
    localparam logic [13:0] INIT_HI = INIT_TW[27:14];
    localparam logic [DIV_W-1:0] FREQ_DIVISOR = DIV_W'(64'(MCLK_HZ) * 64'd2);
    localparam logic [31:0] FREQ_ROUND = 32'(MCLK_HZ);
    // reciprocals: the estimate is at most three low for a frequency, one for a phase
    localparam int unsigned FREQ_SH  = 23;
    localparam int unsigned PHASE_SH = 32;
    localparam logic [31:0] FREQ_RECIP  = 32'((64'd1 << (TW_W + FREQ_SH)) / 64'(MCLK_HZ));
    localparam logic [31:0] PHASE_RECIP = 32'((64'd1 << PHASE_SH) / 64'(PHASE_DIVISOR));
    localparam logic [3:0] INIT_LAST = 4'(INIT_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EST,
        S_BACK,
        S_FIX,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [15:0]      r_shadow;
    logic [2:0]       r_cmd;
    logic             r_hold;
    logic [2:0]       r_mode;
    logic             r_chan;
    logic             r_rej;
    logic [3:0]       r_step;
    logic [1:0]       r_cnt;
    logic [31:0]      r_ma;
    logic [31:0]      r_mb;
    logic [31:0]      r_num;
    logic [31:0]      r_rem;
    logic [DIV_W-1:0] r_div;
    logic [TW_W-1:0]  r_quo;
    logic             r_sat;
    logic             r_out_valid;
    t_res_item        r_out_data;

    logic [63:0]      w_prod;
    logic [TW_W-1:0]  w_est;
    logic             w_fix_ge;
    logic [31:0]      w_pnum;
    logic [TW_W-1:0]  w_tw;
    logic [15:0]      w_word;
    logic [15:0]      w_shadow;
    logic             w_last;
    logic             w_load;
    logic             w_accept;
    logic             w_bad;
    logic [15:0]      w_fpfx;
    logic [15:0]      w_ppfx;

    function automatic logic [15:0] f_mode_word(input logic [15:0] c, input logic [2:0] m);
        logic [15:0] sleeps;
        sleeps = CTL_SLEEP1 | CTL_SLEEP12;
        case (m)
            MODE_OFF:    f_mode_word = (c & ~(CTL_OPBITEN | CTL_MODE)) | sleeps;
            MODE_SINE:   f_mode_word = c & ~(CTL_OPBITEN | CTL_MODE | sleeps);
            MODE_SQFULL: f_mode_word = (c & ~(CTL_MODE | sleeps)) | CTL_OPBITEN | CTL_DIV2;
            MODE_SQHALF: f_mode_word = (c & ~(CTL_MODE | CTL_DIV2 | sleeps)) | CTL_OPBITEN;
            MODE_TRI:    f_mode_word = (c & ~(CTL_OPBITEN | sleeps)) | CTL_MODE;
            default:     f_mode_word = c;
        endcase
    endfunction

    // the one shared multiplier
    assign w_prod   = r_ma * r_mb;
    assign w_est    = (r_cmd == CMD_FREQ) ? w_prod[FREQ_SH +: TW_W] : w_prod[PHASE_SH +: TW_W];
    assign w_fix_ge = r_rem >= 32'(r_div);
    // phase numerator: tenths * 512 + 225
    assign w_pnum   = {7'd0, i_in_data.phase_tenths, PHASE_ROUND};

    assign w_tw     = r_sat ? {TW_W{1'b1}} : r_quo;
    assign w_fpfx   = r_chan ? PFX_FREQ1 : PFX_FREQ0;
    assign w_ppfx   = r_chan ? PFX_PHASE1 : PFX_PHASE0;
    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign w_bad    = (i_in_data.cmd == CMD_MODE
                       && !(i_in_data.wave_mode inside {[MODE_OFF:MODE_TRI]}))
                      || !(i_in_data.cmd inside {[CMD_INIT:CMD_PSEL]});

    // word and shadow for the current step
    always_comb begin
        w_shadow = r_shadow;
        w_word   = r_shadow;
        w_last   = 1'b1;
        case (r_cmd)
            CMD_INIT: begin
                w_last = (r_step == INIT_LAST);
                case (r_step)
                    4'd0:  w_shadow = CTL_B28;
                    4'd1:  w_shadow = r_shadow | CTL_RESET;
                    4'd3:  w_word   = PFX_FREQ0 | {2'b00, INIT_LO};
                    4'd4:  w_word   = PFX_FREQ0 | {2'b00, INIT_HI};
                    4'd6:  w_word   = PFX_FREQ1 | {2'b00, INIT_LO};
                    4'd7:  w_word   = PFX_FREQ1 | {2'b00, INIT_HI};
                    4'd8:  w_word   = PFX_PHASE0;
                    4'd9:  w_word   = PFX_PHASE1;
                    4'd10: w_shadow = r_shadow | CTL_RESET;
                    4'd11: w_shadow = r_shadow & ~CTL_RESET;
                    4'd12: w_shadow = f_mode_word(r_shadow, MODE_SINE);
                    4'd13: w_shadow = r_shadow & ~CTL_FSEL;
                    4'd14: w_shadow = r_shadow & ~CTL_PSEL;
                    default: w_shadow = r_shadow;
                endcase
                if (!(r_step inside {4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9})) begin
                    w_word = w_shadow;
                end
            end
            CMD_RESET: begin
                if (r_step == 4'd0) begin
                    w_shadow = r_shadow | CTL_RESET;
                    w_last   = r_hold;
                end else begin
                    w_shadow = r_shadow & ~CTL_RESET;
                end
                w_word = w_shadow;
            end
            CMD_MODE: begin
                w_shadow = f_mode_word(r_shadow, r_mode);
                w_word   = w_shadow;
            end
            CMD_FREQ: begin
                w_last = (r_step == 4'd2);
                case (r_step)
                    4'd0:    w_word = r_shadow;
                    4'd1:    w_word = w_fpfx | {2'b00, w_tw[13:0]};
                    default: w_word = w_fpfx | {2'b00, w_tw[27:14]};
                endcase
            end
            CMD_PHASE: begin
                w_word = w_ppfx | {4'h0, r_quo[PW_W-1:0]};
            end
            CMD_FSEL: begin
                w_shadow = r_chan ? (r_shadow | CTL_FSEL) : (r_shadow & ~CTL_FSEL);
                w_word   = w_shadow;
            end
            CMD_PSEL: begin
                w_shadow = r_chan ? (r_shadow | CTL_PSEL) : (r_shadow & ~CTL_PSEL);
                w_word   = w_shadow;
            end
            default: begin
                w_word = r_shadow;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shadow    <= 16'h0000;
            r_out_valid <= 1'b0;
            r_step      <= 4'd0;
            r_cnt       <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd  <= i_in_data.cmd;
                        r_hold <= i_in_data.hold;
                        r_mode <= i_in_data.wave_mode;
                        r_chan <= i_in_data.chan;
                        r_rej  <= w_bad;
                        r_step <= 4'd0;
                        r_cnt  <= 2'd2;
                        r_quo  <= '0;
                        r_sat  <= 1'b0;
                        if (i_in_data.cmd == CMD_FREQ) begin
                            r_ma  <= {8'd0, i_in_data.freq_hz};
                            r_mb  <= FREQ_RECIP;
                            // low 32 bits of freq_hz << 29 plus mclk
                            r_num <= {i_in_data.freq_hz[2:0], 29'd0} + FREQ_ROUND;
                            r_div <= FREQ_DIVISOR;
                            // at or above mclk the tuning word saturates
                            if (32'(i_in_data.freq_hz) >= MCLK_HZ) begin
                                r_sat   <= 1'b1;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_EST;
                            end
                        end else if (i_in_data.cmd == CMD_PHASE) begin
                            r_ma    <= w_pnum;
                            r_mb    <= PHASE_RECIP;
                            r_num   <= w_pnum;
                            r_div   <= PHASE_DIVISOR;
                            r_state <= S_EST;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EST: begin
                    r_quo   <= w_est;
                    r_ma    <= 32'(w_est);
                    r_mb    <= 32'(r_div);
                    r_state <= S_BACK;
                end
                S_BACK: begin
                    // true remainder is below 2^30, so the low 32 bits suffice
                    r_rem   <= r_num - w_prod[31:0];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    if (w_fix_ge) begin
                        r_rem <= r_rem - 32'(r_div);
                        r_quo <= r_quo + 1'b1;
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 2'd0) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        if (r_rej) begin
                            r_out_data <= '{spi_word: 16'h0000, last: 1'b1, rejected: 1'b1};
                            r_state    <= S_IDLE;
                        end else begin
                            r_shadow   <= w_shadow;
                            r_out_data <= '{spi_word: w_word, last: w_last, rejected: 1'b0};
                            r_step     <= r_step + 1'b1;
                            if (w_last) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_rej_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rejected |-> o_out_data.last && o_out_data.spi_word == 16'h0000)
        else $error("rejected item carries a word or is not last");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second item taken while a command is in progress");

    a_init_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && r_cmd == CMD_INIT |-> r_step <= INIT_LAST)
        else $error("init sequence ran past its last word");

    a_init_shadow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && !r_rej && r_cmd == CMD_INIT && w_last |=> r_shadow == CTL_B28)
        else $error("shadow after init is not b28 alone");

    a_fix_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIX && r_cnt == 2'd0 |=> r_state == S_EMIT)
        else $error("correction did not hand over to emit");

    a_fix_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && !r_sat && (r_cmd == CMD_FREQ || r_cmd == CMD_PHASE)
        |-> r_rem < 32'(r_div))
        else $error("remainder not below divisor after correction");
`endif

endmodule

`default_nettype wire
